// ===== hdl/udr_pkg.sv =====
// Shared types and constants for the 128-bit unsigned divider.
`timescale 1ns / 1ps

package udr_pkg;

    localparam int HALF_W = 64;
    localparam int FULL_W = 128;

    typedef struct packed {
        logic [HALF_W-1:0] dividend_high;
        logic [HALF_W-1:0] dividend_low;
        logic [HALF_W-1:0] divisor_high;
        logic [HALF_W-1:0] divisor_low;
    } t_in_data;

    typedef struct packed {
        logic [HALF_W-1:0] quotient_high;
        logic [HALF_W-1:0] quotient_low;
        logic [HALF_W-1:0] remainder_high;
        logic [HALF_W-1:0] remainder_low;
        logic              divide_by_zero;
    } t_out_data;

endpackage

// ===== hdl/unsigned_divide_remainder_128.sv =====
// Top level of the pipelined unsigned restoring divider.
`timescale 1ns / 1ps

// Unsigned divider, pipelined one quotient bit per stage: one subtract-and-compare
// stage for each of the OPERAND_WIDTH bits (8..128) follows an input register, so a
// division can be accepted every cycle unless the output stalls; quotient and
// remainder leave the last stage. Only the low OPERAND_WIDTH bits of each operand
// take part. A zero divisor gives divide_by_zero with all other result fields zero.
// The whole pipeline holds while a result waits at the output.
module unsigned_divide_remainder_128 #(
    parameter int OPERAND_WIDTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  udr_pkg::t_in_data  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output udr_pkg::t_out_data o_out_data
);

    localparam int OW = (OPERAND_WIDTH < 8)   ? 8 :
                        (OPERAND_WIDTH > 128) ? 128 : OPERAND_WIDTH;

    logic                       en;
    logic [udr_pkg::FULL_W-1:0] in_dividend;
    logic [udr_pkg::FULL_W-1:0] in_divisor;

    logic          r_valid0;
    logic [OW-1:0] r_dividend0;
    logic [OW-1:0] r_divisor0;
    logic          r_dbz0;

    logic          st_valid [0:OW];
    logic [OW-1:0] st_rem   [0:OW];
    logic [OW-1:0] st_quo   [0:OW];
    logic [OW-1:0] st_div   [0:OW];
    logic          st_dbz   [0:OW];

    logic [udr_pkg::FULL_W-1:0] quo_full;
    logic [udr_pkg::FULL_W-1:0] rem_full;

    assign en          = ~o_out_valid | i_out_ready;
    assign o_in_ready  = en;
    assign in_dividend = {i_in_data.dividend_high, i_in_data.dividend_low};
    assign in_divisor  = {i_in_data.divisor_high, i_in_data.divisor_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (en) begin
            r_valid0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dividend0 <= in_dividend[OW-1:0];
            r_divisor0  <= in_divisor[OW-1:0];
            r_dbz0      <= (in_divisor[OW-1:0] == '0);
        end
    end

    assign st_valid[0] = r_valid0;
    assign st_rem[0]   = '0;
    assign st_quo[0]   = r_dividend0;
    assign st_div[0]   = r_divisor0;
    assign st_dbz[0]   = r_dbz0;

    for (genvar k = 0; k < OW; k++) begin : g_step
        udr_step #(
            .W (OW)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (st_valid[k]),
            .i_rem   (st_rem[k]),
            .i_quo   (st_quo[k]),
            .i_div   (st_div[k]),
            .i_dbz   (st_dbz[k]),
            .o_valid (st_valid[k+1]),
            .o_rem   (st_rem[k+1]),
            .o_quo   (st_quo[k+1]),
            .o_div   (st_div[k+1]),
            .o_dbz   (st_dbz[k+1])
        );
    end

    // drop the quotient and remainder on a zero divisor
    assign quo_full = st_dbz[OW] ? '0 : udr_pkg::FULL_W'(st_quo[OW]);
    assign rem_full = st_dbz[OW] ? '0 : udr_pkg::FULL_W'(st_rem[OW]);

    assign o_out_valid                = st_valid[OW];
    assign o_out_data.quotient_high   = quo_full[udr_pkg::FULL_W-1:udr_pkg::HALF_W];
    assign o_out_data.quotient_low    = quo_full[udr_pkg::HALF_W-1:0];
    assign o_out_data.remainder_high  = rem_full[udr_pkg::FULL_W-1:udr_pkg::HALF_W];
    assign o_out_data.remainder_low   = rem_full[udr_pkg::HALF_W-1:0];
    assign o_out_data.divide_by_zero  = st_dbz[OW];

endmodule

// ===== hdl/udr_step.sv =====
// One registered restoring-division step: shift in one dividend bit, trial subtract.
`timescale 1ns / 1ps

module udr_step #(
    parameter int W = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_quo,
    input  logic [W-1:0] i_div,
    input  logic         i_dbz,
    output logic         o_valid,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_div,
    output logic         o_dbz
);

    logic         r_valid;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_quo;
    logic [W-1:0] r_div;
    logic         r_dbz;

    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         take;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_quo;

    always_comb begin
        rem_sh = {i_rem, i_quo[W-1]};
        diff   = rem_sh - {1'b0, i_div};
        take   = ~diff[W];
        n_rem  = take ? diff[W-1:0] : rem_sh[W-1:0];
        n_quo  = {i_quo[W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_div <= i_div;
            r_dbz <= i_dbz;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_dbz   = r_dbz;

endmodule

// ===== dv/unsigned_divide_remainder_128_tb.sv =====
// Self-checking testbench for the pipelined 128-bit unsigned divider.
`timescale 1ns / 1ps

module unsigned_divide_remainder_128_tb;

    localparam int OPERAND_WIDTH = 128;
    localparam int USED_W = (OPERAND_WIDTH < 8) ? 8 :
                            (OPERAND_WIDTH > 128) ? 128 : OPERAND_WIDTH;
    localparam int LATENCY = USED_W + 1;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT = 200000;

    class division_ledger;
        udr_pkg::t_out_data pending[$];
        int                 mismatches;
        int                 used_w;

        function new(int w);
            used_w = w;
            mismatches = 0;
        endfunction

        function udr_pkg::t_out_data divide(udr_pkg::t_in_data d);
            logic [127:0]       mask;
            logic [127:0]       dvd;
            logic [127:0]       dvs;
            logic [127:0]       quo;
            logic [128:0]       part;
            udr_pkg::t_out_data r;
            int                 i;
            mask = (used_w >= 128) ? {128{1'b1}} : ((128'd1 << used_w) - 128'd1);
            dvd = {d.dividend_high, d.dividend_low} & mask;
            dvs = {d.divisor_high, d.divisor_low} & mask;
            r = '0;
            if (dvs == '0) begin
                r.divide_by_zero = 1'b1;
                return r;
            end
            part = '0;
            quo = '0;
            for (i = used_w - 1; i >= 0; i--) begin
                part = {part[127:0], dvd[i]};
                if (part >= {1'b0, dvs}) begin
                    part = part - {1'b0, dvs};
                    quo[i] = 1'b1;
                end
            end
            r.quotient_high  = quo[127:64];
            r.quotient_low   = quo[63:0];
            r.remainder_high = part[127:64];
            r.remainder_low  = part[63:0];
            return r;
        endfunction

        function void note_operands(udr_pkg::t_in_data d);
            pending = {pending, divide(d)};
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(udr_pkg::t_out_data got);
            udr_pkg::t_out_data want;
            if (pending.size() == 0) begin
                report_mismatch("result transfer with no division outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.quotient_high !== want.quotient_high)
                report_mismatch($sformatf("quotient_high %h, want %h",
                                          got.quotient_high, want.quotient_high));
            if (got.quotient_low !== want.quotient_low)
                report_mismatch($sformatf("quotient_low %h, want %h",
                                          got.quotient_low, want.quotient_low));
            if (got.remainder_high !== want.remainder_high)
                report_mismatch($sformatf("remainder_high %h, want %h",
                                          got.remainder_high, want.remainder_high));
            if (got.remainder_low !== want.remainder_low)
                report_mismatch($sformatf("remainder_low %h, want %h",
                                          got.remainder_low, want.remainder_low));
            if (got.divide_by_zero !== want.divide_by_zero)
                report_mismatch($sformatf("divide_by_zero %b, want %b",
                                          got.divide_by_zero, want.divide_by_zero));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    udr_pkg::t_in_data  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    udr_pkg::t_out_data o_out_data;

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 cycles;
    division_ledger     ledger;

    unsigned_divide_remainder_128 #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("unsigned_divide_remainder_128 test failed");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                ledger.note_operands(i_in_data);
            if (o_out_valid && i_out_ready)
                ledger.check_result(o_out_data);
        end
    end

    function udr_pkg::t_in_data pack_operands(logic [127:0] dvd, logic [127:0] dvs);
        pack_operands = {dvd, dvs};
    endfunction

    function udr_pkg::t_in_data random_operands();
        logic [127:0] dvd;
        logic [127:0] dvs;
        int           pick;
        dvd = {$urandom, $urandom, $urandom, $urandom};
        dvs = {$urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 4)
            dvs = '0;
        else if (pick < 16)
            dvs = dvs | (128'd1 << 127);
        else if (pick < 24)
            dvs = dvs >> $urandom_range(127, 100);
        else
            dvs = dvs >> $urandom_range(127);
        if ($urandom_range(3) != 0)
            dvd = dvd >> $urandom_range(127);
        return pack_operands(dvd, dvs);
    endfunction

    // call and return at a falling edge; valid is left high on return, until the next item or an idle cycle
    task send_item(udr_pkg::t_in_data d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = d;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    int           send_pct[4] = '{0, 49, 0, 8};
    int           recv_pct[4] = '{0, 0, 49, 8};
    logic [127:0] ones = {128{1'b1}};
    logic [127:0] top = 128'd1 << 127;

    initial begin
        int phase;
        ledger = new(USED_W);
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(pack_operands('0, '0));
        send_item(pack_operands(ones, '0));
        send_item(pack_operands('0, ones));
        send_item(pack_operands(ones, ones));
        send_item(pack_operands(ones, 128'd1));
        send_item(pack_operands(128'd1, 128'd1));
        send_item(pack_operands('0, 128'd1));
        send_item(pack_operands(128'd7, 128'd9));
        send_item(pack_operands(ones, top));
        send_item(pack_operands(ones, top | 128'd1));
        send_item(pack_operands(top | 128'd5, top | 128'd3));
        send_item(pack_operands(ones, ones - 128'd1));
        send_item(pack_operands(ones, 128'd1 << 64));
        send_item(pack_operands(128'd1 << 64, ones >> 64));
        send_item(pack_operands(ones >> 64, 128'h1_0000_0001));
        send_item(pack_operands(ones, 128'd1000000007));
        send_item(pack_operands(128'h5555_5555_5555_5555_AAAA_AAAA_AAAA_AAAA,
                                128'hAAAA_AAAA_AAAA_AAAA_5555_5555_5555_5555));

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            repeat (RANDOM_ITEMS / 4) send_item(random_operands());
        end
        i_in_valid = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        if (ledger.mismatches == 0) begin
            $display("unsigned_divide_remainder_128 test passed");
        end else begin
            $display("unsigned_divide_remainder_128 test failed");
        end
        $finish;
    end

endmodule
